>>> src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers on clk / rst_n.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> src/mtf_pkg.sv
// ============================================================================
// Move-to-front list package
// Sizes, action codes, sequencer states and the RAM request type.
// ============================================================================
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int ECNT_W = 9;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> src/mtf_in_if.sv
// ============================================================================
// Command channel
// valid/ready channel carrying one action and its value.
// ============================================================================
`timescale 1ns / 1ps

interface mtf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

>>> src/mtf_out_if.sv
// ============================================================================
// Result channel
// valid/ready channel carrying the outcome of one command.
// ============================================================================
`timescale 1ns / 1ps

interface mtf_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] position;
  logic       rejected;
  logic [8:0] entry_count;

  modport source (output valid, output found, output position, output rejected,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input position, input rejected,
                  input entry_count, output ready);
endinterface

>>> src/mtf_ram.sv
// ============================================================================
// List storage
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module mtf_ram (
  input  logic                        clk,
  input  mtf_pkg::ram_req_t           req,
  output logic [mtf_pkg::DATA_W-1:0]  rd_data
);

  logic [mtf_pkg::DATA_W-1:0] mem [mtf_pkg::DEPTH];
  logic [mtf_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/move_to_front_list.sv
// ============================================================================
// Move-to-front list
// Self-organising list of signed 32-bit values held in a small RAM.
// ============================================================================
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   action[1:0], value[31:0]
//  out_ch   out  valid/ready   found, position[7:0], rejected, entry_count[8:0]
//
// One command at a time, every step through the single RAM port pair.
// A refused insert or an unused action code goes straight to the result; an
// insert shifts every entry back and writes the value at the front; remove and
// search scan from the front to a match (to the end on a miss), then shift the
// entries behind (remove) or before (search) the match, then give the result.
// Reset clears count and control; a stalled result holds the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module move_to_front_list (
  input  logic              clk,
  input  logic              rst_n,
  mtf_in_if.sink            in_ch,
  mtf_out_if.source         out_ch
);

  mtf_pkg::state_t state_r, state_nxt;

  logic [1:0]                 op_r, op_nxt;
  logic [mtf_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [mtf_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [mtf_pkg::CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [mtf_pkg::ADDR_W-1:0] chk_r, chk_nxt;
  logic                       rvalid_r, rvalid_nxt;
  logic [mtf_pkg::ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [mtf_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic                       wp_r, wp_nxt;
  logic [mtf_pkg::ADDR_W-1:0] wa_r, wa_nxt;
  logic                       back_r, back_nxt;
  logic                       found_r, found_nxt;
  logic [mtf_pkg::ADDR_W-1:0] pos_r, pos_nxt;
  logic                       rej_r, rej_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [mtf_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                       out_rej_r, out_rej_nxt;
  logic [mtf_pkg::ECNT_W-1:0] out_cnt_r, out_cnt_nxt;

  mtf_pkg::ram_req_t          ram_req;
  logic [mtf_pkg::DATA_W-1:0] rd_data;

  logic                       in_acc;
  logic                       match;
  logic                       shift_done;
  logic                       out_free;
  logic [mtf_pkg::CNT_W-1:0]  cnt_m1;
  logic [mtf_pkg::CNT_W-1:0]  tail_len;

  mtf_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == mtf_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign match       = rvalid_r && (rd_data == val_r);
  assign shift_done  = (left_r == '0) && !wp_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cnt_m1      = count_r - 1'b1;
  // entries behind the match that move forward on a remove
  assign tail_len    = cnt_m1 - {{(mtf_pkg::CNT_W - mtf_pkg::ADDR_W){1'b0}}, chk_r};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            mtf_pkg::ACT_INSERT: begin
              state_nxt = (count_r == mtf_pkg::CNT_W'(mtf_pkg::DEPTH)) ?
                          mtf_pkg::ST_RESULT : mtf_pkg::ST_SHIFT;
            end
            mtf_pkg::ACT_REMOVE, mtf_pkg::ACT_SEARCH: state_nxt = mtf_pkg::ST_SCAN;
            default: state_nxt = mtf_pkg::ST_RESULT;
          endcase
        end
      end
      mtf_pkg::ST_SCAN: begin
        if (match) begin
          state_nxt = mtf_pkg::ST_SHIFT;
        end else if (ptr_r == count_r) begin
          state_nxt = mtf_pkg::ST_RESULT;
        end
      end
      mtf_pkg::ST_SHIFT: begin
        if (shift_done) begin
          state_nxt = mtf_pkg::ST_RESULT;
        end
      end
      mtf_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = mtf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtf_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ datapath
  always_comb begin
    op_nxt     = op_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    chk_nxt    = chk_r;
    rvalid_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    left_nxt   = left_r;
    wp_nxt     = 1'b0;
    wa_nxt     = wa_r;
    back_nxt   = back_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    rej_nxt    = rej_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_rej_nxt   = out_rej_r;
    out_cnt_nxt   = out_cnt_r;

    ram_req       = '0;
    ram_req.waddr = wa_r;
    ram_req.wdata = rd_data;
    ram_req.raddr = rd_idx_r;

    case (state_r)
      mtf_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_ch.action;
          val_nxt    = in_ch.value;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          rej_nxt    = 1'b0;
          ptr_nxt    = '0;
          // insert: open a slot at the front by moving every entry back
          back_nxt   = 1'b1;
          rd_idx_nxt = cnt_m1[mtf_pkg::ADDR_W-1:0];
          left_nxt   = count_r;
          if (in_ch.action == mtf_pkg::ACT_INSERT &&
              count_r == mtf_pkg::CNT_W'(mtf_pkg::DEPTH)) begin
            rej_nxt = 1'b1;
          end
        end
      end
      mtf_pkg::ST_SCAN: begin
        if (match) begin
          found_nxt = 1'b1;
          pos_nxt   = chk_r;
          if (op_r == mtf_pkg::ACT_REMOVE) begin
            back_nxt   = 1'b0;
            rd_idx_nxt = chk_r + 1'b1;
            left_nxt   = tail_len;
          end else begin
            back_nxt   = 1'b1;
            rd_idx_nxt = chk_r - 1'b1;
            left_nxt   = {{(mtf_pkg::CNT_W - mtf_pkg::ADDR_W){1'b0}}, chk_r};
          end
        end else if (ptr_r != count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r[mtf_pkg::ADDR_W-1:0];
          chk_nxt       = ptr_r[mtf_pkg::ADDR_W-1:0];
          ptr_nxt       = ptr_r + 1'b1;
          rvalid_nxt    = 1'b1;
        end
      end
      mtf_pkg::ST_SHIFT: begin
        // read one entry, write it to its neighbour on the next cycle
        if (wp_r) begin
          ram_req.we = 1'b1;
        end
        if (left_r != '0) begin
          ram_req.re = 1'b1;
          wp_nxt     = 1'b1;
          wa_nxt     = back_r ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
          rd_idx_nxt = back_r ? rd_idx_r - 1'b1 : rd_idx_r + 1'b1;
          left_nxt   = left_r - 1'b1;
        end else if (!wp_r) begin
          if (back_r) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = '0;
            ram_req.wdata = val_r;
          end
          if (op_r == mtf_pkg::ACT_INSERT) begin
            count_nxt = count_r + 1'b1;
          end else if (op_r == mtf_pkg::ACT_REMOVE) begin
            count_nxt = cnt_m1;
          end
        end
      end
      mtf_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = {{(mtf_pkg::POS_W - mtf_pkg::ADDR_W){1'b0}}, pos_r};
          out_rej_nxt   = rej_r;
          out_cnt_nxt   = {{(mtf_pkg::ECNT_W - mtf_pkg::CNT_W){1'b0}}, count_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtf_pkg::ST_IDLE;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      wp_r        <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      wp_r        <= wp_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    chk_r       <= chk_nxt;
    rd_idx_r    <= rd_idx_nxt;
    wa_r        <= wa_nxt;
    back_r      <= back_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    rej_r       <= rej_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_rej_r   <= out_rej_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.rejected    = out_rej_r;
  assign out_ch.entry_count = out_cnt_r;

  // ---------------------------------------------------------------- assertions
  `ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= mtf_pkg::CNT_W'(mtf_pkg::DEPTH))
  `ASSERT_CLK(a_busy_after_cmd, in_acc |=> !in_ch.ready)
  `ASSERT_CLK(a_found_not_rej, out_valid_r |-> !(out_found_r && out_rej_r))
  `ASSERT_CLK(a_no_ram_conflict, ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)

endmodule
